// ===== hw/rtl/crtsb_pkg.sv =====
// ----------------------------------------------------------------------------
// crtsb_pkg
// Shared types, constants and tables for the scanline beam sampler.
// ----------------------------------------------------------------------------
package crtsb_pkg;

  localparam int DEF_MAX_LINES = 256;
  localparam int TAP_COUNT     = 4;

  localparam logic [8:0]  LINE_COUNT_RST = 9'd224;
  localparam logic [12:0] SIGMA_RST      = 13'd2048;
  localparam logic [12:0] ONE_Q12        = 13'd4096;
  localparam logic [16:0] LOG2E_Q16      = 17'd94548;
  localparam logic [17:0] SQRT2PI_Q16    = 18'd164274;
  localparam logic [13:0] OUT_MAX        = 14'd16383;

  localparam logic [1:0] CFG_LINE_COUNT   = 2'd0;
  localparam logic [1:0] CFG_DARK_SIGMA   = 2'd1;
  localparam logic [1:0] CFG_BRIGHT_SIGMA = 2'd2;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic              is_sample;
    logic              wr_ok;
    logic [7:0]        idx;
    logic [12:0]       level;
    logic [15:0]       pos;
    logic signed [9:0] first;
  } crtsb_entry_t;

  typedef struct packed {
    logic [8:0]  line_count;
    logic [12:0] dark_sigma;
    logic [12:0] bright_sigma;
  } crtsb_cfg_t;

  // 2^(-j/16) in Q1.16, entry 16 is one half
  function automatic logic [16:0] pow2_frac(input logic [4:0] j);
    logic [16:0] v;
    unique case (j)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

  function automatic logic [12:0] clamp_sigma(input logic [12:0] s);
    logic [12:0] v;
    if (s == 13'd0) v = 13'd1;
    else if (s > ONE_Q12) v = ONE_Q12;
    else v = s;
    return v;
  endfunction

endpackage

// ===== hw/rtl/crtsb_front.sv =====
// ----------------------------------------------------------------------------
// crtsb_front
// Accepts input transfers, classifies them and computes the first tap line.
// ----------------------------------------------------------------------------
module crtsb_front import crtsb_pkg::*; #(
  parameter int MAX_LINES = DEF_MAX_LINES
) (
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [39:0]  in_tdata,
  input  logic         in_tuser,
  input  logic         q_full,
  output logic         q_push,
  output crtsb_entry_t q_entry
);

  localparam logic [12:0] ML = 13'(MAX_LINES);

  logic [15:0] pos;
  logic [16:0] pos_rnd;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign pos       = in_tdata[36:21];
  assign pos_rnd   = {1'b0, pos} + 17'd128;

  always_comb begin
    q_entry.is_sample = (in_tuser == OP_SAMPLE);
    q_entry.idx       = in_tdata[7:0];
    q_entry.level     = in_tdata[20:8];
    q_entry.pos       = pos;
    q_entry.wr_ok     = ({5'd0, in_tdata[7:0]} < ML);
    q_entry.first     = $signed({1'b0, pos_rnd[16:8]}) - 10'sd2;
  end

endmodule

// ===== hw/rtl/crtsb_fifo.sv =====
// ----------------------------------------------------------------------------
// crtsb_fifo
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module crtsb_fifo import crtsb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  crtsb_entry_t push_entry,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output crtsb_entry_t pop_entry
);

  crtsb_entry_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign valid     = (cnt_r != 2'd0);
  assign pop_entry = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop)  rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hw/rtl/crtsb_back.sv =====
// ----------------------------------------------------------------------------
// crtsb_back
// Line store and sequential tap engine: square root, sigma blend, shared
// restoring divider, exp2 table, accumulation and output register.
// ----------------------------------------------------------------------------
module crtsb_back import crtsb_pkg::*; #(
  parameter int MAX_LINES = DEF_MAX_LINES
) (
  input  logic         clk,
  input  logic         rst_n,
  input  crtsb_cfg_t   cfg,
  input  logic         q_valid,
  input  crtsb_entry_t q_entry,
  output logic         q_pop,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [13:0]  out_intensity
);

  localparam int AW = $clog2(MAX_LINES);
  localparam logic [12:0] ML = 13'(MAX_LINES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_TAP  = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_SQ   = 4'd3;
  localparam logic [3:0] S_SG1  = 4'd4;
  localparam logic [3:0] S_SG2  = 4'd5;
  localparam logic [3:0] S_MUL  = 4'd6;
  localparam logic [3:0] S_MUL2 = 4'd7;
  localparam logic [3:0] S_DV0  = 4'd8;
  localparam logic [3:0] S_DIV  = 4'd9;
  localparam logic [3:0] S_EX   = 4'd10;
  localparam logic [3:0] S_T1   = 4'd11;
  localparam logic [3:0] S_ACC  = 4'd12;
  localparam logic [3:0] S_OUT  = 4'd13;

  localparam logic MODE_U    = 1'b0;
  localparam logic MODE_TERM = 1'b1;

  logic [12:0] mem [MAX_LINES];
  logic [12:0] rd_q;

  logic [3:0]  state_r, state_nxt;
  logic signed [9:0] first_r;
  logic [15:0] pos_r;
  logic [1:0]  k_r;
  logic [15:0] acc_r;
  logic [12:0] lev_r;
  logic [24:0] sq_v_r, sq_bit_r, sq_res_r;
  logic [3:0]  sq_cnt_r;
  logic [25:0] p1_r;
  logic [12:0] sig_r;
  logic [15:0] ad_r;
  logic [31:0] d2_r;
  logic [24:0] s2_r;
  logic [51:0] num_r, rem_r, dsh_r;
  logic [30:0] den_r;
  logic        mode_r, ovf_r;
  logic [16:0] q_r;
  logic [4:0]  dcnt_r;
  logic [24:0] ex_r;
  logic        out_valid_r;
  logic [13:0] out_int_r;

  logic [12:0] dk, br;
  logic [10:0] i_cur;
  logic        in_range;
  logic [AW-1:0] rd_addr;
  logic [24:0] sq_try;
  logic [17:0] dd;
  logic [51:0] den_full, den_half;
  logic [4:0]  qw_last;
  logic [4:0]  ex_n;
  logic [3:0]  ex_f;
  logic [16:0] ex_a, ex_b, ex_e16;
  logic [24:0] ex_prod;
  logic [13:0] term;
  logic [16:0] acc_sum;
  logic        out_load;

  assign dk       = clamp_sigma(cfg.dark_sigma);
  assign br       = clamp_sigma(cfg.bright_sigma);
  assign i_cur    = {first_r[9], first_r} + {9'd0, k_r};
  assign in_range = !i_cur[10] && ({3'd0, i_cur[9:0]} < {4'd0, cfg.line_count})
                    && ({3'd0, i_cur[9:0]} < ML);
  assign rd_addr  = AW'(i_cur[9:0]);
  assign sq_try   = sq_res_r + sq_bit_r;
  assign dd       = {2'b0, pos_r} - {i_cur[9:0], 8'h80};
  assign qw_last  = (mode_r == MODE_U) ? 5'd16 : 5'd13;
  assign den_full = (mode_r == MODE_U) ? (52'(den_r) << 17) : (52'(den_r) << 14);
  assign den_half = (mode_r == MODE_U) ? (52'(den_r) << 16) : (52'(den_r) << 13);

  assign ex_n    = q_r[16:12];
  assign ex_f    = q_r[11:8];
  assign ex_a    = pow2_frac({1'b0, ex_f});
  assign ex_b    = pow2_frac({1'b0, ex_f} + 5'd1);
  assign ex_prod = 25'(ex_a - ex_b) * {17'd0, q_r[7:0]} + 25'd128;
  assign ex_e16  = ex_a - ex_prod[24:8];

  assign term     = ovf_r ? OUT_MAX : q_r[13:0];
  assign acc_sum  = {1'b0, acc_r} + {3'd0, term};
  assign out_load = !out_valid_r || out_tready;

  assign q_pop         = (state_r == S_IDLE) && q_valid;
  assign out_tvalid    = out_valid_r;
  assign out_intensity = out_int_r;

  always_ff @(posedge clk) begin
    if (q_pop && !q_entry.is_sample && q_entry.wr_ok) mem[AW'(q_entry.idx)] <= q_entry.level;
    if (state_r == S_TAP && in_range) rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (q_valid && q_entry.is_sample) state_nxt = S_TAP;
      S_TAP:  begin
        if (in_range) state_nxt = S_RD;
        else if (k_r == 2'd3) state_nxt = S_OUT;
      end
      S_RD:   state_nxt = S_SQ;
      S_SQ:   if (sq_cnt_r == 4'd0) state_nxt = S_SG1;
      S_SG1:  state_nxt = S_SG2;
      S_SG2:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_DV0;
      S_DV0:  begin
        if (num_r >= den_full) state_nxt = (mode_r == MODE_U) ? S_EX : S_ACC;
        else state_nxt = S_DIV;
      end
      S_DIV:  if (dcnt_r == 5'd0) state_nxt = (mode_r == MODE_U) ? S_EX : S_ACC;
      S_EX:   state_nxt = S_T1;
      S_T1:   state_nxt = S_DV0;
      S_ACC:  state_nxt = (k_r == 2'd3) ? S_OUT : S_TAP;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        first_r <= q_entry.first;
        pos_r   <= q_entry.pos;
        k_r     <= 2'd0;
        acc_r   <= 16'd0;
      end
      S_TAP: if (!in_range) k_r <= k_r + 2'd1;
      S_RD: begin
        lev_r    <= (rd_q > ONE_Q12) ? ONE_Q12 : rd_q;
        sq_v_r   <= {((rd_q > ONE_Q12) ? ONE_Q12 : rd_q), 12'd0};
        sq_bit_r <= 25'd1 << 24;
        sq_res_r <= 25'd0;
        sq_cnt_r <= 4'd12;
      end
      S_SQ: begin
        if (sq_v_r >= sq_try) begin
          sq_v_r   <= sq_v_r - sq_try;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
        sq_cnt_r <= sq_cnt_r - 4'd1;
      end
      S_SG1: begin
        p1_r <= 26'(dk) * 26'(ONE_Q12 - sq_res_r[12:0]);
        ad_r <= 16'(dd[17] ? (18'd0 - dd) : dd);
      end
      S_SG2: sig_r <= 13'((p1_r + 26'(br) * 26'(sq_res_r[12:0]) + 26'd2048) >> 12);
      S_MUL: begin
        d2_r <= 32'(ad_r) * 32'(ad_r);
        s2_r <= 25'(sig_r) * 25'(sig_r);
      end
      S_MUL2: begin
        num_r  <= {49'(d2_r) * 49'(LOG2E_Q16), 3'd0};
        den_r  <= 31'(s2_r);
        mode_r <= MODE_U;
      end
      S_DV0: begin
        ovf_r  <= (num_r >= den_full);
        rem_r  <= num_r;
        dsh_r  <= den_half;
        q_r    <= 17'd0;
        dcnt_r <= qw_last;
      end
      S_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[15:0], 1'b1};
        end else begin
          q_r   <= {q_r[15:0], 1'b0};
        end
        dsh_r  <= dsh_r >> 1;
        dcnt_r <= dcnt_r - 5'd1;
      end
      S_EX: ex_r <= ovf_r ? 25'd0 : ({ex_e16, 8'd0} >> ex_n);
      S_T1: begin
        num_r  <= 52'({38'(lev_r) * 38'(ex_r), 4'd0});
        den_r  <= 31'(sig_r) * 31'(SQRT2PI_Q16);
        mode_r <= MODE_TERM;
      end
      S_ACC: begin
        acc_r <= acc_sum[16] ? 16'hFFFF : acc_sum[15:0];
        k_r   <= k_r + 2'd1;
      end
      S_OUT: if (out_load) out_int_r <= (acc_r > {2'd0, OUT_MAX}) ? OUT_MAX : acc_r[13:0];
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_sqrt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ && sq_cnt_r == 4'd0) |=> (sq_res_r <= 25'(ONE_Q12)))
    else $error("square root out of range");
  a_sigma_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (sig_r >= 13'd1 && sig_r <= ONE_Q12))
    else $error("blended sigma out of range");
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < (dsh_r << 1)))
    else $error("divider remainder exceeds bound");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == S_IDLE))
    else $error("queue popped while busy");
`endif

endmodule

// ===== hw/rtl/crt_scanline_beam_sample.sv =====
// ----------------------------------------------------------------------------
// crt_scanline_beam_sample
// Four-tap Gaussian CRT scanline beam sampler with a line store.
// ----------------------------------------------------------------------------
// A level write (tuser 0) is queued and written to the line store by the
// idle back end. A sample (tuser 1) walks its four taps one after another
// through a shared sequential datapath: an in-range tap runs a 13-step square
// root, two passes of a shared one-bit-per-cycle divider of up to 17 and 14
// steps, plus multiply stages; a tap outside the valid line range is skipped.
// A two-entry queue lets input transfers be accepted while the back end
// works.
module crt_scanline_beam_sample import crtsb_pkg::*; #(
  parameter int MAX_LINES = DEF_MAX_LINES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // line_index, line_level, sample_position
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // intensity
);

  crtsb_cfg_t   cfg_r;
  crtsb_entry_t push_entry, pop_entry;
  logic         q_push, q_full, q_valid, q_pop;
  logic [13:0]  intensity;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_count   <= LINE_COUNT_RST;
      cfg_r.dark_sigma   <= SIGMA_RST;
      cfg_r.bright_sigma <= SIGMA_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_LINE_COUNT:   cfg_r.line_count   <= cfg_wr_data[8:0];
        CFG_DARK_SIGMA:   cfg_r.dark_sigma   <= cfg_wr_data;
        CFG_BRIGHT_SIGMA: cfg_r.bright_sigma <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  crtsb_front #(.MAX_LINES(MAX_LINES)) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry)
  );

  crtsb_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .valid      (q_valid),
    .pop_entry  (pop_entry)
  );

  crtsb_back #(.MAX_LINES(MAX_LINES)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_valid       (q_valid),
    .q_entry       (pop_entry),
    .q_pop         (q_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_intensity (intensity)
  );

  assign out_tdata = {2'b00, intensity};

endmodule
